/* src/pal_pkg.sv */
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants of the positional array list engine.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 5;
  localparam int FIELD_W  = 5;   // width of found_position and entry_count

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_END   = 3'd1,
    ACT_INS_POS   = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_END   = 3'd4,
    ACT_DEL_POS   = 3'd5,
    ACT_SEARCH    = 3'd6,
    ACT_DUMP      = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_BADPOS   = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,   // cells above idx take left, cell idx takes new_value
    OP_DEL  = 2'd2,   // cells from idx up take right
    OP_ROT  = 2'd3    // cells below idx take right, cell idx takes new_value
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic [IDX_W-1:0]        idx;
    logic [VAL_W-1:0]        new_value;
    logic [VAL_W-1:0]        key;
    logic [CNT_W-1:0]        count;
  } cell_ctl_t;

endpackage

/* src/pal_cell.sv */
// ----------------------------------------------------------------------------
// pal_cell
// One list slot: holds an entry, shifts with its neighbors, matches a key.
// ----------------------------------------------------------------------------
module pal_cell (
  input  logic                      clk,
  input  logic [pal_pkg::IDX_W-1:0] cell_idx,
  input  pal_pkg::cell_ctl_t        ctl,
  input  logic [pal_pkg::VAL_W-1:0] left_value,
  input  logic [pal_pkg::VAL_W-1:0] right_value,
  input  logic                      seen_in,
  output logic [pal_pkg::VAL_W-1:0] value,
  output logic                      seen_out,
  output logic                      first_hit
);

  localparam int CW = pal_pkg::CNT_W;

  logic occupied;
  logic hit;

  assign occupied  = CW'(cell_idx) < ctl.count;
  assign hit       = occupied && (value == ctl.key);
  assign seen_out  = seen_in | hit;
  assign first_hit = hit & ~seen_in;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      pal_pkg::OP_HOLD: begin
        value <= value;
      end
      pal_pkg::OP_INS: begin
        if (cell_idx > ctl.idx) begin
          value <= left_value;
        end else if (cell_idx == ctl.idx) begin
          value <= ctl.new_value;
        end
      end
      pal_pkg::OP_DEL: begin
        if (cell_idx >= ctl.idx) begin
          value <= right_value;
        end
      end
      pal_pkg::OP_ROT: begin
        if (cell_idx < ctl.idx) begin
          value <= right_value;
        end else if (cell_idx == ctl.idx) begin
          value <= ctl.new_value;
        end
      end
    endcase
  end

endmodule

/* src/positional_array_list_engine.sv */
// Latency: a result item is registered and appears in the cycle after its input item is accepted;
//   the first entry of a dump passes the state register, then the output register, and can stall.
// Throughput: one item per cycle for insert, delete and search while the output is not stalled;
//   a dump emits one result per cycle while not stalled and holds the input until its last entry.
// Reset: rst (synchronous, active high) empties the list and the output
//   register; entry storage is not cleared.
// ----------------------------------------------------------------------------
// positional_array_list_engine
// Ordered list of signed 32-bit entries kept in a chain of shifting cells,
// with insert, delete, search and dump actions.
// ----------------------------------------------------------------------------
module positional_array_list_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] elem_value, [36:32] position, rest zero
  input  logic [2:0]  s_tuser,   // [2:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [4:0] found_position, [36:5] entry_value,
                                 // [41:37] entry_count, rest zero
  output logic [2:0]  m_tuser,   // [2:0] status
  output logic        m_tlast    // last
);

  localparam int CAP    = pal_pkg::CAPACITY;
  localparam int IW     = pal_pkg::IDX_W;
  localparam int CW     = pal_pkg::CNT_W;
  localparam int VW     = pal_pkg::VAL_W;
  localparam int PW     = pal_pkg::POS_W;
  localparam int FW     = pal_pkg::FIELD_W;
  localparam int CMP_W  = ((CW > PW) ? CW : PW) + 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // list size and dump progress
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] remain;
  logic [CW-1:0] dump_pos;

  // output register
  logic                  out_valid;
  pal_pkg::status_t      out_status;
  logic [FW-1:0]         out_fpos;
  logic [VW-1:0]         out_value;
  logic [FW-1:0]         out_count;
  logic                  out_last;

  // input fields
  pal_pkg::action_t in_action;
  logic [VW-1:0]    in_value;
  logic [PW-1:0]    in_pos;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;

  logic slot_free;
  logic in_accept;
  logic emit;

  // decoded action
  pal_pkg::status_t  res_status;
  logic [CW-1:0]     res_fpos;
  pal_pkg::cell_op_t dec_op;
  logic [IW-1:0]     dec_idx;
  logic              dump_start;
  logic              list_full;
  logic              list_empty;

  // chain
  pal_pkg::cell_ctl_t ctl;
  logic [VW-1:0]      cell_value [CAP];
  logic [CAP:0]       seen;
  logic [CAP-1:0]     first_hit;
  logic [CW-1:0]      match_pos;

  assign in_action = pal_pkg::action_t'(s_tuser);
  assign in_value  = s_tdata[VW-1:0];
  assign in_pos    = s_tdata[VW+PW-1:VW];
  assign pos_ext   = CMP_W'(in_pos);
  assign cnt_ext   = CMP_W'(count);

  assign list_full  = (count == CW'(CAP));
  assign list_empty = (count == '0);

  // Accept a new item only while idle and the output slot can take a result.
  assign slot_free = !out_valid || m_tready;
  assign s_tready  = (state == S_IDLE) && slot_free;
  assign in_accept = s_tvalid && s_tready;
  assign emit      = (state == S_DUMP) && slot_free;

  // --------------------------------------------------------------------------
  // Cell chain. Each cell sees its two neighbors; the search flag ripples up
  // from cell 0 so only the lowest matching occupied cell reports a hit.
  // --------------------------------------------------------------------------
  assign seen[0] = 1'b0;

  for (genvar g = 0; g < CAP; g++) begin : g_cell
    logic [VW-1:0] left_v;
    logic [VW-1:0] right_v;

    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_value[g-1];
    end

    if (g == CAP - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_value[g+1];
    end

    pal_cell u_cell (
      .clk         (clk),
      .cell_idx    (IW'(g)),
      .ctl         (ctl),
      .left_value  (left_v),
      .right_value (right_v),
      .seen_in     (seen[g]),
      .value       (cell_value[g]),
      .seen_out    (seen[g+1]),
      .first_hit   (first_hit[g])
    );
  end

  // At most one first_hit is set; fold it into a 1-based position.
  always_comb begin
    match_pos = '0;
    for (int i = 0; i < CAP; i++) begin
      if (first_hit[i]) begin
        match_pos = match_pos | CW'(i + 1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Action decode: status, new count and the command for the chain.
  // Full and empty checks come before the position check.
  // --------------------------------------------------------------------------
  always_comb begin
    res_status = pal_pkg::STAT_OK;
    res_fpos   = '0;
    count_next = count;
    dec_op     = pal_pkg::OP_HOLD;
    dec_idx    = '0;
    dump_start = 1'b0;
    unique case (in_action)
      pal_pkg::ACT_INS_FRONT: begin
        if (list_full) begin
          res_status = pal_pkg::STAT_FULL;
        end else begin
          dec_op     = pal_pkg::OP_INS;
          count_next = count + CW'(1);
        end
      end
      pal_pkg::ACT_INS_END: begin
        if (list_full) begin
          res_status = pal_pkg::STAT_FULL;
        end else begin
          dec_op     = pal_pkg::OP_INS;
          dec_idx    = IW'(count);
          count_next = count + CW'(1);
        end
      end
      pal_pkg::ACT_INS_POS: begin
        if (list_full) begin
          res_status = pal_pkg::STAT_FULL;
        end else if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
          res_status = pal_pkg::STAT_BADPOS;
        end else begin
          dec_op     = pal_pkg::OP_INS;
          dec_idx    = IW'(pos_ext - CMP_W'(1));
          count_next = count + CW'(1);
        end
      end
      pal_pkg::ACT_DEL_FRONT: begin
        if (list_empty) begin
          res_status = pal_pkg::STAT_EMPTY;
        end else begin
          dec_op     = pal_pkg::OP_DEL;
          count_next = count - CW'(1);
        end
      end
      pal_pkg::ACT_DEL_END: begin
        if (list_empty) begin
          res_status = pal_pkg::STAT_EMPTY;
        end else begin
          dec_op     = pal_pkg::OP_DEL;
          dec_idx    = IW'(count - CW'(1));
          count_next = count - CW'(1);
        end
      end
      pal_pkg::ACT_DEL_POS: begin
        if (list_empty) begin
          res_status = pal_pkg::STAT_EMPTY;
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          res_status = pal_pkg::STAT_BADPOS;
        end else begin
          dec_op     = pal_pkg::OP_DEL;
          dec_idx    = IW'(pos_ext - CMP_W'(1));
          count_next = count - CW'(1);
        end
      end
      pal_pkg::ACT_SEARCH: begin
        if (seen[CAP]) begin
          res_fpos = match_pos;
        end else begin
          res_status = pal_pkg::STAT_NOTFOUND;
        end
      end
      pal_pkg::ACT_DUMP: begin
        if (list_empty) begin
          res_status = pal_pkg::STAT_EMPTY;
        end else begin
          dump_start = 1'b1;
        end
      end
    endcase
  end

  // Chain command. During a dump, rotate the occupied cells down by one per
  // emitted item, wrapping cell 0 to the top; after count steps the list is
  // back in its original order.
  always_comb begin
    ctl.key       = in_value;
    ctl.count     = count;
    ctl.op        = pal_pkg::OP_HOLD;
    ctl.idx       = '0;
    ctl.new_value = in_value;
    if (state == S_DUMP) begin
      ctl.op        = emit ? pal_pkg::OP_ROT : pal_pkg::OP_HOLD;
      ctl.idx       = IW'(count - CW'(1));
      ctl.new_value = cell_value[0];
    end else if (in_accept) begin
      ctl.op  = dec_op;
      ctl.idx = dec_idx;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept && dump_start) begin
          state_next = S_DUMP;
        end
      end
      S_DUMP: begin
        if (emit && remain == CW'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remain    <= '0;
      dump_pos  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_accept) begin
        count    <= count_next;
        remain   <= count;
        dump_pos <= CW'(1);
      end else if (emit) begin
        remain   <= remain - CW'(1);
        dump_pos <= dump_pos + CW'(1);
      end
      // Hold the result until taken; load a new one when the slot frees.
      if ((in_accept && !dump_start) || emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload: no reset needed.
  always_ff @(posedge clk) begin
    if (in_accept && !dump_start) begin
      out_status <= res_status;
      out_fpos   <= FW'(res_fpos);
      out_value  <= '0;
      out_count  <= FW'(count_next);
      out_last   <= 1'b1;
    end else if (emit) begin
      out_status <= pal_pkg::STAT_OK;
      out_fpos   <= FW'(dump_pos);
      out_value  <= cell_value[0];
      out_count  <= FW'(count);
      out_last   <= (remain == CW'(1));
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;
  assign m_tdata  = {6'd0, out_count, out_value, out_fpos};

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAP))
    else $error("list count beyond capacity");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    (in_accept && dec_op == pal_pkg::OP_INS) |=> count == $past(count) + CW'(1))
    else $error("successful insert did not grow the list");

  a_del_shrinks: assert property (@(posedge clk) disable iff (rst)
    (in_accept && dec_op == pal_pkg::OP_DEL) |=> count == $past(count) - CW'(1))
    else $error("successful delete did not shrink the list");

  a_dump_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |=> count == $past(count))
    else $error("list count changed during a dump");

  a_dump_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |-> (count != '0 && remain != '0))
    else $error("dump running on an empty list");
`endif

endmodule

/* dv/positional_array_list_engine_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_engine_test
// Self-checking bench for the list engine. Commands are pushed through the
// input stream, mirrored in a queue-based shadow list, and every result item
// is checked against the predicted reply in order.
// ----------------------------------------------------------------------------
module positional_array_list_engine_test;

  typedef struct {
    pal_pkg::action_t          act;
    logic [pal_pkg::VAL_W-1:0] value;
    logic [pal_pkg::POS_W-1:0] pos;
  } list_cmd_t;

  typedef struct {
    pal_pkg::status_t          status;
    logic [4:0]                where;
    logic [pal_pkg::VAL_W-1:0] value;
    logic [4:0]                count;
    logic                      last;
  } list_reply_t;

  typedef enum int {GROW, SHRINK, MIXED, NOISE} burst_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;   // [31:0] elem_value, [36:32] position, rest zero
  logic [2:0]  s_tuser  = '0;   // [2:0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;         // [4:0] found_position, [36:5] entry_value,
                                // [41:37] entry_count, rest zero
  logic [2:0]  m_tuser;         // [2:0] status
  logic        m_tlast;

  list_cmd_t                 cmd_q[$];     // commands waiting for the driver
  list_reply_t               reply_q[$];   // replies predicted but not yet seen
  logic [pal_pkg::VAL_W-1:0] shadow_list[$];
  list_cmd_t                 on_wire;
  int                        cmds_loaded   = 0;
  int                        cmds_taken    = 0;
  int                        mismatches    = 0;
  int                        send_gap_pct  = 32;
  int                        stall_pct     = 64;

  positional_array_list_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one accepted command to the shadow list and queue its replies.
  task automatic apply_list_action(input list_cmd_t c);
    list_reply_t      r;
    pal_pkg::status_t st;
    logic [4:0]       where;
    int               n;
    bit               dumped;
    begin
      st     = pal_pkg::STAT_OK;
      where  = '0;
      dumped = 1'b0;
      n      = shadow_list.size();
      case (c.act)
        pal_pkg::ACT_INS_FRONT: begin
          if (n >= pal_pkg::CAPACITY) st = pal_pkg::STAT_FULL;
          else shadow_list.push_front(c.value);
        end
        pal_pkg::ACT_INS_END: begin
          if (n >= pal_pkg::CAPACITY) st = pal_pkg::STAT_FULL;
          else shadow_list.push_back(c.value);
        end
        pal_pkg::ACT_INS_POS: begin
          // full wins over a bad position
          if (n >= pal_pkg::CAPACITY) st = pal_pkg::STAT_FULL;
          else if (c.pos == 0 || int'(c.pos) > n + 1) st = pal_pkg::STAT_BADPOS;
          else shadow_list.insert(int'(c.pos) - 1, c.value);
        end
        pal_pkg::ACT_DEL_FRONT: begin
          if (n == 0) st = pal_pkg::STAT_EMPTY;
          else void'(shadow_list.pop_front());
        end
        pal_pkg::ACT_DEL_END: begin
          if (n == 0) st = pal_pkg::STAT_EMPTY;
          else void'(shadow_list.pop_back());
        end
        pal_pkg::ACT_DEL_POS: begin
          // empty wins over a bad position
          if (n == 0) st = pal_pkg::STAT_EMPTY;
          else if (c.pos == 0 || int'(c.pos) > n) st = pal_pkg::STAT_BADPOS;
          else shadow_list.delete(int'(c.pos) - 1);
        end
        pal_pkg::ACT_SEARCH: begin
          st = pal_pkg::STAT_NOTFOUND;
          for (int i = 0; i < n; i++) begin
            if (shadow_list[i] == c.value) begin
              st    = pal_pkg::STAT_OK;
              where = 5'(i + 1);
              break;
            end
          end
        end
        default: begin
          // dump: one reply per entry, or a single empty reply
          if (n == 0) st = pal_pkg::STAT_EMPTY;
          else begin
            dumped = 1'b1;
            for (int i = 0; i < n; i++) begin
              r = '{pal_pkg::STAT_OK, 5'(i + 1), shadow_list[i], 5'(n), i == n - 1};
              reply_q.push_back(r);
            end
          end
        end
      endcase
      if (!dumped) begin
        r = '{st, where, '0, 5'(shadow_list.size()), 1'b1};
        reply_q.push_back(r);
      end
    end
  endtask

  task automatic flag_mismatch(input string what);
    begin
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $time, what);
    end
  endtask

  // Driver: account for the item taken at this edge, then present the next.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_list_action(on_wire);
        cmds_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          on_wire  = cmd_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {3'b000, on_wire.pos, on_wire.value};
          s_tuser  <= on_wire.act;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, compare each accepted item with the oldest reply.
  always @(posedge clk) begin
    list_reply_t want;
    list_reply_t got;
    m_tready <= ($urandom_range(99) >= stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      got = '{pal_pkg::status_t'(m_tuser), m_tdata[4:0], m_tdata[36:5], m_tdata[41:37],
              m_tlast};
      if (reply_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected item st=%0d pos=%0d val=%h cnt=%0d last=%b",
                                got.status, got.where, got.value, got.count, got.last));
      end else begin
        want = reply_q.pop_front();
        if (got.status !== want.status || got.where !== want.where ||
            got.value !== want.value || got.count !== want.count ||
            got.last !== want.last)
          flag_mismatch($sformatf(
            "exp st=%0d pos=%0d val=%h cnt=%0d last=%b, got st=%0d pos=%0d val=%h cnt=%0d last=%b",
            want.status, want.where, want.value, want.count, want.last,
            got.status, got.where, got.value, got.count, got.last));
      end
    end
  end

  task automatic push_cmd(input pal_pkg::action_t act,
                          input logic [pal_pkg::VAL_W-1:0] value,
                          input logic [pal_pkg::POS_W-1:0] pos);
    list_cmd_t c;
    begin
      c = '{act, value, pos};
      cmd_q.push_back(c);
      cmds_loaded++;
    end
  endtask

  function automatic logic [pal_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return ($urandom_range(0, 1) != 0) ? 32'h0 : 32'hffff_ffff;
      3, 4, 5, 6: return 32'($urandom_range(0, 7));   // small pool so searches hit
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [pal_pkg::POS_W-1:0] pick_pos();
    if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(1, 17));
  endfunction

  function automatic pal_pkg::action_t pick_action(input burst_t mode);
    int r;
    begin
      r = $urandom_range(0, 99);
      case (mode)
        GROW: begin
          if (r < 85)      return pal_pkg::action_t'($urandom_range(0, 2));
          else if (r < 90) return pal_pkg::action_t'($urandom_range(3, 5));
          else if (r < 97) return pal_pkg::ACT_SEARCH;
          else             return pal_pkg::ACT_DUMP;
        end
        SHRINK: begin
          if (r < 75)      return pal_pkg::action_t'($urandom_range(3, 5));
          else if (r < 85) return pal_pkg::action_t'($urandom_range(0, 2));
          else if (r < 95) return pal_pkg::ACT_SEARCH;
          else             return pal_pkg::ACT_DUMP;
        end
        default: return pal_pkg::action_t'($urandom_range(0, 7));
      endcase
    end
  endfunction

  // Bursts that fill and drain the list, so full and empty come up again and again.
  task automatic load_random(input int total);
    burst_t mode;
    int     len;
    int     done;
    begin
      done = 0;
      while (done < total) begin
        if (done == 0) begin
          mode = GROW;
          len  = 24;
        end else begin
          mode = burst_t'($urandom_range(0, 3));
          len  = $urandom_range(8, 24);
        end
        for (int i = 0; i < len && done < total; i++) begin
          if (mode == NOISE)
            push_cmd(pal_pkg::action_t'($urandom_range(0, 7)), $urandom,
                     5'($urandom_range(0, 31)));
          else
            push_cmd(pick_action(mode), pick_value(), pick_pos());
          done++;
        end
      end
    end
  endtask

  // Corner cases on an empty and a short list.
  task automatic load_directed();
    begin
      push_cmd(pal_pkg::ACT_DUMP,      32'h0, 5'd0);
      push_cmd(pal_pkg::ACT_DEL_FRONT, 32'h0, 5'd0);
      push_cmd(pal_pkg::ACT_DEL_END,   32'h0, 5'd0);
      push_cmd(pal_pkg::ACT_DEL_POS,   32'h0, 5'd1);
      push_cmd(pal_pkg::ACT_SEARCH,    32'h0, 5'd0);
      push_cmd(pal_pkg::ACT_INS_POS,   32'h1, 5'd0);    // position zero
      push_cmd(pal_pkg::ACT_INS_POS,   32'h1, 5'd2);    // past count+1
      push_cmd(pal_pkg::ACT_INS_POS,   32'h5, 5'd1);
      push_cmd(pal_pkg::ACT_INS_FRONT, 32'h8000_0000, 5'd0);
      push_cmd(pal_pkg::ACT_INS_END,   32'h7fff_ffff, 5'd0);
      push_cmd(pal_pkg::ACT_INS_POS,   32'hffff_ffff, 5'd4);   // append via count+1
      push_cmd(pal_pkg::ACT_SEARCH,    32'h7fff_ffff, 5'd0);
      push_cmd(pal_pkg::ACT_SEARCH,    32'h0000_1234, 5'd0);
      push_cmd(pal_pkg::ACT_DUMP,      32'h0, 5'd0);
      push_cmd(pal_pkg::ACT_DEL_POS,   32'h0, 5'd0);
      push_cmd(pal_pkg::ACT_DEL_POS,   32'h0, 5'd31);
      push_cmd(pal_pkg::ACT_DEL_POS,   32'h0, 5'd5);
      push_cmd(pal_pkg::ACT_DEL_POS,   32'h0, 5'd2);
      push_cmd(pal_pkg::ACT_DEL_END,   32'h0, 5'd0);
      push_cmd(pal_pkg::ACT_DEL_FRONT, 32'h0, 5'd0);
      push_cmd(pal_pkg::ACT_DUMP,      32'h0, 5'd0);
    end
  endtask

  // Hold off new commands until every item sent has been answered.
  task automatic wait_drained();
    begin
      while (cmds_taken != cmds_loaded || reply_q.size() != 0) @(posedge clk);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 32;
          stall_pct    = 64;
          load_directed();
        end
        1: begin
          send_gap_pct = 64;
          stall_pct    = 32;
        end
        default: begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
      endcase
      load_random(110);
      wait_drained();
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
